// File: hdl/power_subset_instruction_executor_defines.svh
// Assertion macros shared by the executor RTL.
`ifndef POWER_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define POWER_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PSIE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("psie: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PSIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("psie: next-cycle check failed");

`endif

// File: hdl/psie_pkg.sv
`timescale 1ns / 1ps

package psie_pkg;

	// register file geometry
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = 5;
	localparam int PC_W      = 16;

	// format tags
	localparam logic [2:0] MODE_X  = 3'd0;
	localparam logic [2:0] MODE_XO = 3'd1;
	localparam logic [2:0] MODE_D  = 3'd2;
	localparam logic [2:0] MODE_B  = 3'd3;
	localparam logic [2:0] MODE_DS = 3'd4;

	// primary opcodes
	localparam logic [5:0] PO_ARITH  = 6'd31;
	localparam logic [5:0] PO_ADDI   = 6'd14;
	localparam logic [5:0] PO_BRANCH = 6'd19;

	// extended opcodes
	localparam logic [9:0] XO_NAND = 10'd476;
	localparam logic [9:0] XO_OR   = 10'd444;
	localparam logic [9:0] XO_AND  = 10'd28;
	localparam logic [9:0] XO_XOR  = 10'd316;
	localparam logic [8:0] XO_ADD  = 9'd266;
	localparam logic [8:0] XO_SUBF = 9'd40;

	// configuration register index (paddr[2])
	localparam logic CFG_PROG_LEN = 1'b0;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_NAND,
		OP_OR,
		OP_AND,
		OP_XOR,
		OP_ADD,
		OP_SUBF,
		OP_ADDI,
		OP_BEQ
	} op_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] instr;
	} cmd_t;

	typedef struct packed {
		logic [PC_W-1:0]      next_pc;
		logic                 reg_write;
		logic [REG_IDX_W-1:0] reg_index;
		logic signed [63:0]   reg_value;
		logic                 done_res;
	} res_t;

	// decoded instruction
	typedef struct packed {
		op_t                  op;
		logic                 wr;
		logic [REG_IDX_W-1:0] addr_a;
		logic [REG_IDX_W-1:0] addr_b;
		logic [REG_IDX_W-1:0] widx;
		logic [15:0]          imm;
	} dec_t;

endpackage

// File: hdl/psie_decode.sv
`timescale 1ns / 1ps

module psie_decode import psie_pkg::*; (
	input  cmd_t cmd,
	output dec_t dec
);

	logic [31:0]          w;
	logic [5:0]           po;
	logic [REG_IDX_W-1:0] f1, f2, f3;

	assign w  = cmd.instr;
	assign po = w[31:26];
	assign f1 = w[25:21];
	assign f2 = w[20:16];
	assign f3 = w[15:11];

	// format and opcode decode
	always_comb begin
		dec.op     = OP_NOP;
		dec.addr_a = f1;
		dec.addr_b = f3;
		dec.widx   = '0;
		dec.imm    = '0;
		unique case (cmd.mode)
			MODE_X: begin
				if (po == PO_ARITH) begin
					dec.widx = f2;
					priority if (w[10:1] == XO_NAND) dec.op = OP_NAND;
					else if (w[10:1] == XO_OR)       dec.op = OP_OR;
					else if (w[10:1] == XO_AND)      dec.op = OP_AND;
					else if (w[10:1] == XO_XOR)      dec.op = OP_XOR;
					else                             dec.op = OP_NOP;
				end
			end
			MODE_XO: begin
				// OE and Rc must be clear
				if (po == PO_ARITH && !w[10] && !w[0]) begin
					dec.addr_a = f2;
					dec.widx   = f1;
					priority if (w[9:1] == XO_ADD) dec.op = OP_ADD;
					else if (w[9:1] == XO_SUBF)    dec.op = OP_SUBF;
					else                           dec.op = OP_NOP;
				end
			end
			MODE_D: begin
				if (po == PO_ADDI) begin
					dec.op     = OP_ADDI;
					dec.addr_a = f2;
					dec.widx   = f1;
					dec.imm    = w[15:0];
				end
			end
			MODE_B: begin
				// AA and LK must be clear
				if (po == PO_BRANCH && !w[1] && !w[0]) begin
					dec.op     = OP_BEQ;
					dec.addr_a = f1;
					dec.addr_b = f2;
					dec.imm    = {{2{w[15]}}, w[15:2]};
				end
			end
			default: ;
		endcase
		dec.wr = (dec.op != OP_NOP) && (dec.op != OP_BEQ);
	end

endmodule

// File: hdl/power_subset_instruction_executor.sv
`timescale 1ns / 1ps
// channel | direction | payload | handshake
// cmd     | into      | cmd_t   | cmd_valid / cmd_stall
// res     | out of    | res_t   | res_valid / res_stall
// cfg     | into      | 32 bit  | APB-style, pready tied high
//
// One instruction per cycle sustained while res_stall is low; a beat passes the
// execute stage, then the output register. Operands come from a synchronous register
// file read at the command beat; the previous instruction's write-back is forwarded
// into the operands. Reset clears the counter, program_length and the per-register
// valid bits. cmd_stall rises only when the execute stage is full and the output
// register is held by res_stall.

`include "power_subset_instruction_executor_defines.svh"

module power_subset_instruction_executor import psie_pkg::*; #(
	parameter int REG_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [PC_W-1:0] plen_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_PROG_LEN) begin
			plen_q <= pwdata[PC_W-1:0];
		end
	end

	assign prdata = (paddr[2] == CFG_PROG_LEN) ? {16'b0, plen_q} : '0;

	// decode
	dec_t dec;

	psie_decode u_dec (
		.cmd (cmd),
		.dec (dec)
	);

	// pipeline control
	logic vld_s1;
	logic adv;
	logic accept;

	assign adv       = vld_s1 && (!res_valid || !res_stall);
	assign cmd_stall = vld_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;

	// execute-stage registers
	op_t                  op_s1;
	logic                 wr_s1;
	logic [REG_IDX_W-1:0] addr_a_s1, addr_b_s1, widx_s1;
	logic [15:0]          imm_s1;
	logic                 byp_a_s1, byp_b_s1;
	logic [REG_WIDTH-1:0] byp_val_s1;
	logic [REG_WIDTH-1:0] rd_a_s1, rd_b_s1;

	// register file and its valid bits
	logic [REG_WIDTH-1:0] rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [REG_WIDTH-1:0] alu_val;
	logic                 wb_en;

	assign wb_en = adv && wr_s1;

	always_ff @(posedge clk) begin
		if (wb_en) begin
			rf_mem[widx_s1] <= alu_val;
		end
		if (accept) begin
			rd_a_s1 <= rf_mem[dec.addr_a];
			rd_b_s1 <= rf_mem[dec.addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wb_en) begin
			rf_vld_q[widx_s1] <= 1'b1;
		end
	end

	// stage 1 capture, with forwarding of the write retiring this edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= dec.op;
			wr_s1      <= dec.wr;
			addr_a_s1  <= dec.addr_a;
			addr_b_s1  <= dec.addr_b;
			widx_s1    <= dec.widx;
			imm_s1     <= dec.imm;
			byp_a_s1   <= wb_en && (widx_s1 == dec.addr_a);
			byp_b_s1   <= wb_en && (widx_s1 == dec.addr_b);
			byp_val_s1 <= alu_val;
		end
	end

	// operand select: forwarded, stored, or reset value
	logic [REG_WIDTH-1:0] opa, opb;

	assign opa = byp_a_s1 ? byp_val_s1 : (rf_vld_q[addr_a_s1] ? rd_a_s1 : '0);
	assign opb = byp_b_s1 ? byp_val_s1 : (rf_vld_q[addr_b_s1] ? rd_b_s1 : '0);

	// ALU
	always_comb begin
		unique case (op_s1)
			OP_NAND: alu_val = ~(opa & opb);
			OP_OR:   alu_val = opa | opb;
			OP_AND:  alu_val = opa & opb;
			OP_XOR:  alu_val = opa ^ opb;
			OP_ADD:  alu_val = opa + opb;
			OP_SUBF: alu_val = opb - opa;
			OP_ADDI: alu_val = opa + REG_WIDTH'(signed'(imm_s1));
			default: alu_val = '0;
		endcase
	end

	// instruction counter
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] step;
	logic [PC_W-1:0] next_pc;

	assign step    = (op_s1 == OP_BEQ && opa == opb) ? imm_s1 : PC_W'(1);
	assign next_pc = pc_q + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (adv) begin
			pc_q <= next_pc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.next_pc   <= next_pc;
			res.reg_write <= wr_s1;
			res.reg_index <= wr_s1 ? widx_s1 : '0;
			res.reg_value <= wr_s1 ? 64'(signed'(alu_val)) : '0;
			res.done_res  <= (next_pc == plen_q);
		end
	end

	// checks
	`PSIE_ASSERT_IMPL(a_nowr_zero, clk, arst_n, res_valid && !res.reg_write, res.reg_index == '0 && res.reg_value == '0)
	`PSIE_ASSERT_NEXT(a_pc_hold, clk, arst_n, !adv, $stable(pc_q))
	`PSIE_ASSERT_NEXT(a_wb_valid, clk, arst_n, wb_en, rf_vld_q[$past(widx_s1)])
	`PSIE_ASSERT_IMPL(a_stall_full, clk, arst_n, cmd_stall, vld_s1 && res_valid && res_stall)

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import psie_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	power_subset_instruction_executor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// architectural state mirrored by the predictor
	logic [63:0] gpr [REG_COUNT];
	logic [15:0] pc = '0;
	logic [15:0] prog_len = '0;

	cmd_t insn_queue[$];
	res_t exec_results[$];
	res_t want;
	int   errors = 0;
	int   cycles = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;

	initial begin
		for (int i = 0; i < REG_COUNT; i++) begin
			gpr[i] = '0;
		end
	end

	// idle run length: none unless a pct draw hits, else short, now and then long
	function automatic int pick_idle(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 30);
		return $urandom_range(1, 3);
	endfunction

	// low registers half the time so that back-to-back hazards are common
	function automatic logic [4:0] pick_reg();
		logic [4:0] r;
		if ($urandom_range(0, 1))
			r = 5'($urandom_range(0, 3));
		else
			r = 5'($urandom_range(0, 31));
		return r;
	endfunction

	// execute one instruction on the mirrored state, return its result beat
	function automatic res_t exec_insn(input cmd_t c);
		logic [31:0] w;
		logic [4:0]  f1, f2, f3;
		logic [15:0] step;
		logic        wr;
		logic [63:0] val;
		res_t        r;
		w    = c.instr;
		f1   = w[25:21];
		f2   = w[20:16];
		f3   = w[15:11];
		step = 16'd1;
		wr   = 1'b0;
		val  = '0;
		if (c.mode == MODE_X && w[31:26] == PO_ARITH) begin
			wr = 1'b1;
			case (w[10:1])
				XO_NAND: val = ~(gpr[f1] & gpr[f3]);
				XO_OR:   val = gpr[f1] | gpr[f3];
				XO_AND:  val = gpr[f1] & gpr[f3];
				XO_XOR:  val = gpr[f1] ^ gpr[f3];
				default: wr = 1'b0;
			endcase
			f1 = f2;
		end else if (c.mode == MODE_XO && w[31:26] == PO_ARITH && !w[10] && !w[0]) begin
			wr = 1'b1;
			case (w[9:1])
				XO_ADD:  val = gpr[f2] + gpr[f3];
				XO_SUBF: val = gpr[f3] - gpr[f2];
				default: wr = 1'b0;
			endcase
		end else if (c.mode == MODE_D && w[31:26] == PO_ADDI) begin
			wr  = 1'b1;
			val = gpr[f2] + {{48{w[15]}}, w[15:0]};
		end else if (c.mode == MODE_B && w[31:26] == PO_BRANCH && !w[1] && !w[0]) begin
			if (gpr[f1] == gpr[f2])
				step = {{2{w[15]}}, w[15:2]};
		end
		// f1 holds the destination index at this point
		if (wr)
			gpr[f1] = val;
		pc = pc + step;
		r.next_pc   = pc;
		r.reg_write = wr;
		r.reg_index = wr ? f1 : 5'd0;
		r.reg_value = wr ? val : 64'd0;
		r.done_res  = (pc == prog_len);
		return r;
	endfunction

	// command driver: predicts each beat as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else if (!cmd_valid || !cmd_stall) begin
			if (cmd_valid)
				exec_results.push_back(exec_insn(cmd));
			if (gap_left > 0) begin
				cmd_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (insn_queue.size() != 0) begin
				cmd_valid <= 1'b1;
				cmd <= insn_queue.pop_front();
				gap_left <= pick_idle(gap_pct);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (exec_results.size() == 0) begin
					$error("result beat with nothing pending: next_pc %0d", res.next_pc);
					errors++;
				end else begin
					want = exec_results.pop_front();
					if (res.next_pc !== want.next_pc) begin
						$error("next_pc: expected %0d, got %0d", want.next_pc, res.next_pc);
						errors++;
					end
					if (res.reg_write !== want.reg_write) begin
						$error("reg_write: expected %0b, got %0b", want.reg_write, res.reg_write);
						errors++;
					end
					if (res.reg_index !== want.reg_index) begin
						$error("reg_index: expected %0d, got %0d", want.reg_index, res.reg_index);
						errors++;
					end
					if (res.reg_value !== want.reg_value) begin
						$error("reg_value: expected %h, got %h", want.reg_value, res.reg_value);
						errors++;
					end
					if (res.done_res !== want.done_res) begin
						$error("done_res: expected %0b, got %0b", want.done_res, res.done_res);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				res_stall <= 1'b0;
				stall_left <= pick_idle(stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_insn(input logic [2:0] m, input logic [31:0] w);
		insn_queue.push_back(cmd_t'{mode: m, instr: w});
	endtask

	// wait until every beat is issued and every result is back
	task automatic wait_quiet();
		do @(negedge clk); while (insn_queue.size() != 0 || cmd_valid || exec_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// setup then access phase; the write lands with pready high
	task automatic set_program_length(input logic [15:0] len);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {CFG_PROG_LEN, 2'b00};
		pwdata  <= {16'd0, len};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		prog_len = len;
	endtask

	// mostly well-formed instructions with random operands, some broken, some noise
	task automatic queue_random_program(input int n);
		int          k;
		logic [2:0]  m;
		logic [31:0] w;
		logic [4:0]  rt, ra, rb;
		logic [9:0]  xo10;
		logic [15:0] si;
		logic [13:0] bd;
		for (int i = 0; i < n; i++) begin
			k  = $urandom_range(0, 99);
			m  = MODE_X;
			w  = $urandom;
			rt = pick_reg();
			ra = pick_reg();
			rb = pick_reg();
			if (k < 28) begin
				case ($urandom_range(0, 3))
					0: xo10 = XO_NAND;
					1: xo10 = XO_OR;
					2: xo10 = XO_AND;
					default: xo10 = XO_XOR;
				endcase
				w = {PO_ARITH, rt, ra, rb, xo10, w[0]};
			end else if (k < 48) begin
				m = MODE_XO;
				w = {PO_ARITH, rt, ra, rb, 1'b0, $urandom_range(0, 1) ? XO_ADD : XO_SUBF, 1'b0};
			end else if (k < 68) begin
				m = MODE_D;
				if ($urandom_range(0, 1))
					si = w[15:0];
				else
					si = 16'($urandom_range(0, 15) - 8);
				w = {PO_ADDI, rt, ra, si};
			end else if (k < 80) begin
				m = MODE_B;
				if ($urandom_range(0, 1))
					ra = rt;
				// short hops keep the counter near program_length
				if ($urandom_range(0, 7) == 0)
					bd = w[15:2];
				else
					bd = 14'($urandom_range(0, 12) - 4);
				w = {PO_BRANCH, rt, ra, bd, 2'b00};
			end else if (k < 90) begin
				case ($urandom_range(0, 5))
					0: begin
						m = MODE_XO;
						w = {PO_ARITH, rt, ra, rb, 1'b1, XO_ADD, w[0]};
					end
					1: begin
						m = MODE_XO;
						w = {PO_ARITH, rt, ra, rb, w[10], XO_SUBF, 1'b1};
					end
					2: begin
						m = MODE_B;
						w = {PO_BRANCH, rt, rt, w[15:2], 1'b1, w[0]};
					end
					3: begin
						m = MODE_B;
						w = {PO_BRANCH, rt, rt, w[15:2], w[1], 1'b1};
					end
					4: begin
						m = $urandom_range(0, 1) ? MODE_X : MODE_XO;
						w = {PO_ARITH, rt, ra, rb, w[10:0]};
					end
					default: begin
						// DS and unknown tags on an otherwise valid add
						m = 3'($urandom_range(4, 7));
						w = {PO_ARITH, rt, ra, rb, 1'b0, XO_ADD, 1'b0};
					end
				endcase
			end else begin
				m = 3'($urandom_range(0, 7));
			end
			queue_insn(m, w);
		end
	endtask

	initial begin
		logic [15:0] len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: immediates at the extremes, every operation, no-op forms, branches
		queue_insn(MODE_D,  {PO_ADDI, 5'd1, 5'd0, 16'h7FFF});
		queue_insn(MODE_D,  {PO_ADDI, 5'd2, 5'd0, 16'h8000});
		queue_insn(MODE_D,  {PO_ADDI, 5'd0, 5'd0, 16'hFFFF});
		queue_insn(MODE_D,  {PO_ADDI, 5'd3, 5'd0, 16'h0001});
		queue_insn(MODE_X,  {PO_ARITH, 5'd1, 5'd4, 5'd2, XO_NAND, 1'b0});
		queue_insn(MODE_X,  {PO_ARITH, 5'd1, 5'd5, 5'd2, XO_OR, 1'b1});
		queue_insn(MODE_X,  {PO_ARITH, 5'd0, 5'd6, 5'd1, XO_AND, 1'b0});
		queue_insn(MODE_X,  {PO_ARITH, 5'd0, 5'd7, 5'd2, XO_XOR, 1'b0});
		queue_insn(MODE_XO, {PO_ARITH, 5'd8, 5'd0, 5'd0, 1'b0, XO_ADD, 1'b0});
		queue_insn(MODE_XO, {PO_ARITH, 5'd9, 5'd1, 5'd2, 1'b0, XO_SUBF, 1'b0});
		queue_insn(MODE_XO, {PO_ARITH, 5'd10, 5'd1, 5'd2, 1'b1, XO_ADD, 1'b0});
		queue_insn(MODE_XO, {PO_ARITH, 5'd10, 5'd1, 5'd2, 1'b0, XO_ADD, 1'b1});
		queue_insn(MODE_X,  {PO_ARITH, 5'd1, 5'd11, 5'd2, 10'd0, 1'b0});
		queue_insn(MODE_B,  {PO_BRANCH, 5'd3, 5'd3, 14'd5, 2'b00});
		queue_insn(MODE_B,  {PO_BRANCH, 5'd4, 5'd4, 14'h2000, 2'b00});
		queue_insn(MODE_B,  {PO_BRANCH, 5'd0, 5'd1, 14'd9, 2'b00});
		queue_insn(MODE_B,  {PO_BRANCH, 5'd3, 5'd3, 14'd7, 2'b10});
		queue_insn(MODE_B,  {PO_BRANCH, 5'd3, 5'd3, 14'd7, 2'b01});
		queue_insn(MODE_DS, {PO_ARITH, 5'd1, 5'd2, 5'd3, 1'b0, XO_ADD, 1'b0});
		queue_insn(3'd7,    {PO_ARITH, 5'd1, 5'd2, 5'd3, 1'b0, XO_ADD, 1'b0});
		queue_insn(MODE_X,  {PO_ADDI, 5'd1, 5'd12, 16'h1234});
		queue_insn(MODE_X,  32'hFFFF_FFFF);
		queue_insn(MODE_X,  32'h0000_0000);
		queue_insn(MODE_D,  {PO_ADDI, 5'd31, 5'd31, 16'h0000});
		queue_insn(MODE_X,  {PO_ARITH, 5'd31, 5'd31, 5'd31, XO_NAND, 1'b0});

		// random phases, each starting from a quiet block with a new length
		for (int p = 0; p < 8; p++) begin
			wait_quiet();
			case (p)
				0: len = 16'hFFFF;
				1: len = 16'h0000;
				5: len = 16'($urandom);
				default: len = 16'(pc + $urandom_range(1, 60));
			endcase
			set_program_length(len);
			case (p % 3)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 20;
					stall_pct = 30;
				end
				default: begin
					gap_pct = 50;
					stall_pct = 60;
				end
			endcase
			queue_random_program(150);
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/psie_pkg.sv
hdl/psie_decode.sv
hdl/power_subset_instruction_executor.sv
tb/sv/tb.sv
